// ===== rtl/core/wgm_pkg.sv =====
package wgm_pkg;

  localparam int MAX_PATTERN_CHARS = 32;
  localparam int LEN_W             = 6;
  localparam int COL_W             = $clog2(MAX_PATTERN_CHARS + 1);
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 6;
  localparam int CHAR_W            = 8;
  localparam int CHARS_PER_REG     = CFG_DATA_W / CHAR_W;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [2:0] {
    REG_LENGTH  = 3'd0,
    REG_CHARS_0 = 3'd1,
    REG_CHARS_1 = 3'd2,
    REG_CHARS_2 = 3'd3,
    REG_CHARS_3 = 3'd4
  } wgm_reg_e;

  typedef logic [MAX_PATTERN_CHARS-1:0][CHAR_W-1:0] wgm_pattern_t;

  typedef struct packed {
    logic init;
    logic cur;
    logic adv;
    logic res;
  } wgm_link_t;

endpackage

// ===== rtl/core/wgm_cfg.sv =====
module wgm_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  output logic [wgm_pkg::LEN_W-1:0]             pat_len,
  output wgm_pkg::wgm_pattern_t                 pat_chars
);
  import wgm_pkg::*;

  logic [LEN_W-1:0] len_r;
  wgm_pattern_t     chars_r;
  wgm_reg_e         reg_sel;
  logic             wr_en;

  assign reg_sel   = wgm_reg_e'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en     = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign pat_len   = len_r;
  assign pat_chars = chars_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      chars_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LENGTH:  len_r <= pwdata[LEN_W-1:0];
        REG_CHARS_0: chars_r[0*CHARS_PER_REG +: CHARS_PER_REG] <= pwdata;
        REG_CHARS_1: chars_r[1*CHARS_PER_REG +: CHARS_PER_REG] <= pwdata;
        REG_CHARS_2: chars_r[2*CHARS_PER_REG +: CHARS_PER_REG] <= pwdata;
        REG_CHARS_3: chars_r[3*CHARS_PER_REG +: CHARS_PER_REG] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, len_r};
      REG_CHARS_0: prdata = chars_r[0*CHARS_PER_REG +: CHARS_PER_REG];
      REG_CHARS_1: prdata = chars_r[1*CHARS_PER_REG +: CHARS_PER_REG];
      REG_CHARS_2: prdata = chars_r[2*CHARS_PER_REG +: CHARS_PER_REG];
      REG_CHARS_3: prdata = chars_r[3*CHARS_PER_REG +: CHARS_PER_REG];
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/wgm_cell.sv =====
module wgm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wgm_pkg::CHAR_W-1:0]    pat_char,
  input  logic [wgm_pkg::CHAR_W-1:0]    name_byte,
  input  logic                          start,
  input  logic                          no_char,
  input  logic                          step,
  input  wgm_pkg::wgm_link_t            left,
  output wgm_pkg::wgm_link_t            right
);
  import wgm_pkg::*;

  logic is_star;
  logic hit;
  logic init;
  logic cur;
  logic adv;
  logic row_r;
  logic row_nxt;

  assign is_star = (pat_char == STAR_CHAR);
  assign hit     = (pat_char == ANY_CHAR) || (pat_char == name_byte);
  assign init    = is_star & left.init;
  assign cur     = start ? init : row_r;
  assign adv     = is_star ? (left.adv | cur | left.cur) : (hit & left.cur);
  assign row_nxt = no_char ? cur : adv;

  assign right.init = init;
  assign right.cur  = cur;
  assign right.adv  = adv;
  assign right.res  = row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 1'b0;
    end else if (step) begin
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/core/wildcard_glob_matcher_unit.sv =====
// Channel  Signals                                         Word
// in       in_valid/in_ready, in_name_byte, in_last_byte,  one name character
//          in_no_char
// out      out_valid/out_ready, out_matched                match flag per name
// cfg      psel/penable/pwrite/paddr/pwdata/prdata/pready  length and pattern chars
//
// One word per cycle while in_ready is high: all 32 pattern cells update together.
// A name's result leaves from an output register in the cycle after its last word.
// A new word is taken while the result is pending if out_ready is high.
// Synchronous active-low reset clears the pattern, the row and the output valid bit.
module wildcard_glob_matcher_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_name_byte,
  input  logic                              in_last_byte,
  input  logic                              in_no_char,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_matched,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import wgm_pkg::*;

  logic [LEN_W-1:0] pat_len;
  wgm_pattern_t     pat_chars;
  wgm_link_t        link [0:MAX_PATTERN_CHARS];
  logic             in_fire;
  logic             start_r;
  logic             start_nxt;
  logic             row0_r;
  logic             row0_cur;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_matched_r;
  logic             out_matched_nxt;
  logic [COL_W-1:0] col;

  wgm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pat_len   (pat_len),
    .pat_chars (pat_chars)
  );

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign row0_cur     = start_r | row0_r;
  assign link[0].init = 1'b1;
  assign link[0].cur  = row0_cur;
  assign link[0].adv  = 1'b0;
  assign link[0].res  = in_no_char & row0_cur;

  for (genvar j = 1; j <= MAX_PATTERN_CHARS; j++) begin : g_cell
    wgm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pat_char  (pat_chars[j-1]),
      .name_byte (in_name_byte),
      .start     (start_r),
      .no_char   (in_no_char),
      .step      (in_fire),
      .left      (link[j-1]),
      .right     (link[j])
    );
  end

  always_comb begin
    if (pat_len > LEN_W'(MAX_PATTERN_CHARS)) begin
      col = COL_W'(MAX_PATTERN_CHARS);
    end else begin
      col = COL_W'(pat_len);
    end
  end

  always_comb begin
    start_nxt       = start_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      start_nxt = in_last_byte;
      if (in_last_byte) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = link[col].res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b1;
      row0_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        row0_r <= link[0].res;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

// ===== rtl/core/wgm_checker.sv =====
module wgm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last_byte,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched))
    else $error("result word changed while stalled");

  a_no_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> out_valid)
    else $error("last word accepted without a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_byte && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result without a last word");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_matched  (out_matched)
);

// ===== tb/sv/wgm_glob_checker.sv =====
`timescale 1ns / 1ps

module wgm_glob_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_name_byte,
  input  logic                           in_last_byte,
  input  logic                           in_no_char,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_matched,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending_names,
  output int                             names_checked,
  output int                             names_matched
);
  import wgm_pkg::*;

  logic [LEN_W-1:0]             pattern_len;
  wgm_pattern_t                 pattern;
  logic [MAX_PATTERN_CHARS:0]   glob_row;
  logic                         name_start;
  logic                         match_q[$];
  logic                         want_match;
  logic                         hit;

  function automatic logic [COL_W-1:0] match_column(input logic [LEN_W-1:0] len);
    if (len > MAX_PATTERN_CHARS) return COL_W'(MAX_PATTERN_CHARS);
    return COL_W'(len);
  endfunction

  function automatic logic [MAX_PATTERN_CHARS:0] start_row(input wgm_pattern_t p);
    logic [MAX_PATTERN_CHARS:0] r;
    r = '0;
    r[0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN_CHARS; j++) begin
      r[j] = (p[j-1] == STAR_CHAR) && r[j-1];
    end
    return r;
  endfunction

  function automatic logic [MAX_PATTERN_CHARS:0] advance_row(
    input wgm_pattern_t p,
    input logic [MAX_PATTERN_CHARS:0] r,
    input logic [7:0] c
  );
    logic [MAX_PATTERN_CHARS:0] nxt;
    nxt = '0;
    for (int j = 1; j <= MAX_PATTERN_CHARS; j++) begin
      if (p[j-1] == STAR_CHAR) begin
        nxt[j] = nxt[j-1] | r[j] | r[j-1];
      end else if (p[j-1] == ANY_CHAR || p[j-1] == c) begin
        nxt[j] = r[j-1];
      end
    end
    return nxt;
  endfunction

  // returns 1 when the word closes a name; hit then holds the match flag
  function automatic bit predict_word(
    input logic [7:0] c,
    input logic last,
    input logic none,
    output logic match
  );
    if (name_start) glob_row = start_row(pattern);
    if (!none) glob_row = advance_row(pattern, glob_row, c);
    match = glob_row[match_column(pattern_len)];
    name_start = last;
    return last;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pattern_len   = '0;
      pattern       = '0;
      glob_row      = '0;
      name_start    = 1'b1;
      match_q.delete();
      fail_count    = 0;
      names_checked = 0;
      names_matched = 0;
      pending_names <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (wgm_reg_e'(paddr[5:3]))
          REG_LENGTH:  pattern_len    = pwdata[LEN_W-1:0];
          REG_CHARS_0: pattern[7:0]   = pwdata;
          REG_CHARS_1: pattern[15:8]  = pwdata;
          REG_CHARS_2: pattern[23:16] = pwdata;
          REG_CHARS_3: pattern[31:24] = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          $error("out_matched: no result expected, actual %0b", out_matched);
          fail_count++;
        end else begin
          want_match = match_q.pop_front();
          if (want_match !== out_matched) begin
            $error("out_matched: expected %0b, actual %0b", want_match, out_matched);
            fail_count++;
          end
          names_checked++;
          if (want_match) names_matched++;
        end
      end
      if (in_valid && in_ready) begin
        if (predict_word(in_name_byte, in_last_byte, in_no_char, hit)) begin
          match_q.insert(match_q.size(), hit);
        end
      end
      pending_names <= match_q.size();
    end
  end

endmodule

// ===== tb/sv/wildcard_glob_matcher_unit_tb.sv =====
`timescale 1ns / 1ps

module wildcard_glob_matcher_unit_tb;
  import wgm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_name_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  in_no_char = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_matched;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int           fail_count;
  int           pending_names;
  int           names_checked;
  int           names_matched;
  int           words_sent = 0;
  int           settings_used = 0;
  int           out_hold = 0;
  bit           steady = 1'b0;
  wgm_pattern_t pat_chars = '0;
  logic [7:0]   name_chars[$];

  always #2 clk = ~clk;

  wildcard_glob_matcher_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_name_byte (in_name_byte),
    .in_last_byte (in_last_byte),
    .in_no_char   (in_no_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_matched  (out_matched),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  wgm_glob_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_name_byte  (in_name_byte),
    .in_last_byte  (in_last_byte),
    .in_no_char    (in_no_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_matched   (out_matched),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_names (pending_names),
    .names_checked (names_checked),
    .names_matched (names_matched)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_valid && out_ready) begin
      out_hold = steady ? 0 : $urandom_range(0, 3);
      out_ready <= (out_hold == 0);
    end else if (out_hold != 0) begin
      out_hold--;
      out_ready <= (out_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h61;
      4, 5:       return 8'h62;
      6:          return STAR_CHAR;
      7:          return ANY_CHAR;
      8:          return 8'h63;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_char(input logic [7:0] b, input logic last, input logic none);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_name_byte <= b;
    in_last_byte <= last;
    in_no_char   <= none;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_name(input int blank_pct);
    bit tail_blank;
    tail_blank = (name_chars.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (name_chars[k]) begin
      if ($urandom_range(1, 100) <= blank_pct) push_char(8'($urandom), 1'b0, 1'b1);
      push_char(name_chars[k], !tail_blank && (k == name_chars.size() - 1), 1'b0);
    end
    if (tail_blank) push_char(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic load_name(input string s);
    name_chars.delete();
    for (int i = 0; i < s.len(); i++) name_chars.insert(name_chars.size(), s[i]);
  endtask

  // follow the pattern, then damage the name now and then
  task automatic build_name(input int len);
    int eff;
    int idx;
    eff = (len > MAX_PATTERN_CHARS) ? MAX_PATTERN_CHARS : len;
    name_chars.delete();
    for (int i = 0; i < eff; i++) begin
      if (pat_chars[i] == STAR_CHAR) begin
        repeat ($urandom_range(0, 3)) name_chars.insert(name_chars.size(), pick_char());
      end else if (pat_chars[i] == ANY_CHAR) begin
        name_chars.insert(name_chars.size(), pick_char());
      end else begin
        name_chars.insert(name_chars.size(), pat_chars[i]);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      idx = (name_chars.size() == 0) ? 0 : $urandom_range(0, name_chars.size() - 1);
      case ($urandom_range(0, 2))
        0: if (name_chars.size() != 0) name_chars[idx] = pick_char();
        1: if (name_chars.size() != 0) name_chars.delete(idx);
        default: name_chars.insert(idx, pick_char());
      endcase
    end
  endtask

  task automatic cfg_write(input wgm_reg_e r, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_pattern(input int len);
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    v[LEN_W-1:0] = LEN_W'(len);
    cfg_write(REG_LENGTH, v);
    cfg_write(REG_CHARS_0, pat_chars[7:0]);
    cfg_write(REG_CHARS_1, pat_chars[15:8]);
    cfg_write(REG_CHARS_2, pat_chars[23:16]);
    cfg_write(REG_CHARS_3, pat_chars[31:24]);
    settings_used++;
  endtask

  task automatic fill_pattern(input string s);
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      pat_chars[i] = (i < s.len()) ? s[i] : 8'($urandom);
    end
  endtask

  // drop valid, drain every pending result, then let the pipeline settle
  task automatic settle_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_names != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int len;
    int phase;
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    name_chars.delete();
    send_name(0);
    load_name("a");
    send_name(0);

    settle_idle();
    fill_pattern("a*?b");
    write_pattern(4);
    load_name("axb");
    send_name(0);
    load_name("aXYZb");
    send_name(0);
    load_name("ab");
    send_name(0);
    push_char(8'h61, 1'b0, 1'b0);
    push_char(8'hFF, 1'b0, 1'b1);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(8'hFF, 1'b0, 1'b0);
    push_char(8'h62, 1'b1, 1'b0);

    settle_idle();
    fill_pattern("**a");
    write_pattern(3);
    name_chars.delete();
    send_name(0);
    load_name("a");
    send_name(0);

    settle_idle();
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) pat_chars[i] = STAR_CHAR;
    write_pattern(63);
    name_chars.delete();
    send_name(0);
    load_name("abc");
    send_name(0);

    settle_idle();
    fill_pattern("ab");
    write_pattern(2);
    push_char(8'h61, 1'b0, 1'b0);
    settle_idle();
    pat_chars[1] = 8'h78;
    cfg_write(REG_CHARS_0, pat_chars[7:0]);
    push_char(8'h78, 1'b1, 1'b0);

    phase = 0;
    while (words_sent < 520) begin
      settle_idle();
      steady = (phase % 4 == 3);
      for (int i = 0; i < MAX_PATTERN_CHARS; i++) pat_chars[i] = pick_char();
      case (phase % 6)
        0:       len = 0;
        1:       len = MAX_PATTERN_CHARS;
        2:       len = (phase % 12 == 2) ? 63 : $urandom_range(33, 62);
        default: len = $urandom_range(1, 8);
      endcase
      write_pattern(len);
      phase_start = words_sent;
      while (words_sent - phase_start < 40) begin
        build_name(len);
        send_name(8);
      end
      phase++;
    end
    settle_idle();

    $display("Sent %0d words as %0d names (%0d matched) over %0d pattern settings,",
             words_sent, names_checked, names_matched, settings_used);
    $display("covering empty, clamped, star-only and mid-name pattern changes.");
    if (fail_count == 0 && pending_names == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
